// File: hw/rtl/grid_cell_lod_triangle_indices_macros.svh
// ---------------------------------------------------------------------------
// grid cell lod triangle indices assertion macros
// concurrent assertion helpers, empty when synthesizing
// ---------------------------------------------------------------------------
`ifndef GRID_CELL_LOD_TRIANGLE_INDICES_MACROS_SVH
`define GRID_CELL_LOD_TRIANGLE_INDICES_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define GCLTI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");
// next-cycle implication
`define GCLTI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: %m");
`else
`define GCLTI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GCLTI_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: hw/rtl/gclti_pkg.sv
// ---------------------------------------------------------------------------
// gclti_pkg
// shared constants and types of the grid cell triangle index generator
// ---------------------------------------------------------------------------
`default_nettype none

package gclti_pkg;

    // block geometry
    localparam int BLOCK_DIM  = 8;
    localparam int LOD_LEVELS = 3;
    localparam int DETAIL     = 1 << (LOD_LEVELS - 1);
    localparam int PITCH      = BLOCK_DIM * DETAIL + 1;
    localparam int ROW_STRIDE = DETAIL * PITCH;
    localparam int MAX_STEP   = LOD_LEVELS - 1;

    // field widths
    localparam int IDX_W    = 16;
    localparam int ROWCOL_W = 3;
    localparam int STEP_W   = 2;
    localparam int CNT_W    = LOD_LEVELS;

    // indices written per quad
    localparam int IDX_INC = 6;

    // command queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [IDX_W-1:0] t_idx;

    // classified cell, ready for the walker
    typedef struct packed {
        logic              restart;
        t_idx              base;
        logic [STEP_W-1:0] step;
    } t_cmd;

    // queue status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

`default_nettype wire

// File: hw/rtl/gclti_if.sv
// ---------------------------------------------------------------------------
// gclti channel interfaces
// valid / ready channels for cells in and quads out
// ---------------------------------------------------------------------------
`default_nettype none

interface gclti_in_if;
    import gclti_pkg::*;

    logic                valid;
    logic                ready;
    logic                restart;
    logic [ROWCOL_W-1:0] row;
    logic [ROWCOL_W-1:0] col;
    logic [STEP_W-1:0]   step_log;

    modport source (output valid, output restart, output row, output col,
                    output step_log, input ready);
    modport sink   (input valid, input restart, input row, input col,
                    input step_log, output ready);
endinterface

interface gclti_out_if;
    import gclti_pkg::*;

    logic       valid;
    logic       ready;
    logic [IDX_W-1:0] tri0_v0;
    logic [IDX_W-1:0] tri0_v1;
    logic [IDX_W-1:0] tri0_v2;
    logic [IDX_W-1:0] tri1_v0;
    logic [IDX_W-1:0] tri1_v1;
    logic [IDX_W-1:0] tri1_v2;
    logic [IDX_W-1:0] slot;
    logic       last_quad;

    modport source (output valid, output tri0_v0, output tri0_v1, output tri0_v2,
                    output tri1_v0, output tri1_v1, output tri1_v2, output slot,
                    output last_quad, input ready);
    modport sink   (input valid, input tri0_v0, input tri0_v1, input tri0_v2,
                    input tri1_v0, input tri1_v1, input tri1_v2, input slot,
                    input last_quad, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/gclti_front.sv
// ---------------------------------------------------------------------------
// gclti_front
// accepts cell beats, clamps the step and works out the base vertex index
// ---------------------------------------------------------------------------
`default_nettype none

module gclti_front (
    gclti_in_if.sink           i_in,
    input  gclti_pkg::t_q_stat i_q_stat,
    output logic               o_push,
    output gclti_pkg::t_cmd    o_cmd
);
    import gclti_pkg::*;

    logic [STEP_W-1:0] w_step;
    t_idx              w_row_off;
    t_idx              w_col_off;

    // take a beat whenever the queue has room
    assign i_in.ready = !i_q_stat.full;
    assign o_push     = i_in.valid && !i_q_stat.full;

    // clamp steps coarser than one quad per cell
    assign w_step = (i_in.step_log > STEP_W'(MAX_STEP)) ? STEP_W'(MAX_STEP) : i_in.step_log;

    // base = row * detail * pitch + col * detail, kept modulo 2^16
    assign w_row_off = IDX_W'(32'(i_in.row) * 32'(ROW_STRIDE));
    assign w_col_off = IDX_W'(i_in.col) << (LOD_LEVELS - 1);

    assign o_cmd.restart = i_in.restart;
    assign o_cmd.base    = w_row_off + w_col_off;
    assign o_cmd.step    = w_step;

endmodule

`default_nettype wire

// File: hw/rtl/gclti_queue.sv
// ---------------------------------------------------------------------------
// gclti_queue
// short command queue between the front and the quad walker
// ---------------------------------------------------------------------------
`default_nettype none

module gclti_queue (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  gclti_pkg::t_cmd    i_cmd,
    input  wire                i_pop,
    output gclti_pkg::t_cmd    o_cmd,
    output gclti_pkg::t_q_stat o_stat
);
    import gclti_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_cmd        = r_mem[r_rd_ptr];

    // pointer wrap and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/gclti_back.sv
// ---------------------------------------------------------------------------
// gclti_back
// walks the sub-quads of one cell and registers one quad beat per cycle unless the sink stalls
// ---------------------------------------------------------------------------
`default_nettype none

module gclti_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  gclti_pkg::t_cmd    i_cmd,
    input  gclti_pkg::t_q_stat i_q_stat,
    output logic               o_pop,
    gclti_out_if.source        o_out
);
    import gclti_pkg::*;

    // walker state
    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_a;
    logic [CNT_W-1:0]  r_b;
    t_idx              r_i0;
    t_idx              r_row_i0;
    t_idx              r_count;
    logic              n_busy;
    logic [STEP_W-1:0] n_step;
    logic [CNT_W-1:0]  n_a;
    logic [CNT_W-1:0]  n_b;
    t_idx              n_i0;
    t_idx              n_row_i0;
    t_idx              n_count;

    // output register
    logic r_out_valid;
    t_idx r_v0, r_v1, r_diag, r_down, r_slot;
    logic r_last;
    logic n_out_valid;

    logic             w_emit;
    logic [CNT_W-1:0] w_s_cnt;
    t_idx             w_s;
    t_idx             w_span;
    logic             w_row_end;
    logic             w_col_end;
    logic             w_last;

    // stride and lattice span for the current step
    assign w_s_cnt = CNT_W'(1) << r_step;
    assign w_s     = IDX_W'(w_s_cnt);
    assign w_span  = IDX_W'(PITCH) << r_step;

    assign w_row_end = (r_b + w_s_cnt) >= CNT_W'(DETAIL);
    assign w_col_end = (r_a + w_s_cnt) >= CNT_W'(DETAIL);
    assign w_last    = w_row_end && w_col_end;

    // handshakes
    assign w_emit = r_busy && (!r_out_valid || o_out.ready);
    assign o_pop  = !r_busy && !i_q_stat.empty;

    // next walker state
    always_comb begin
        n_busy   = r_busy;
        n_step   = r_step;
        n_a      = r_a;
        n_b      = r_b;
        n_i0     = r_i0;
        n_row_i0 = r_row_i0;
        n_count  = r_count;
        if (o_pop) begin
            n_busy   = 1'b1;
            n_step   = i_cmd.step;
            n_a      = '0;
            n_b      = '0;
            n_i0     = i_cmd.base;
            n_row_i0 = i_cmd.base;
            if (i_cmd.restart) begin
                n_count = '0;
            end
        end else if (w_emit) begin
            n_count = r_count + IDX_W'(IDX_INC);
            if (w_last) begin
                n_busy = 1'b0;
            end else if (w_row_end) begin
                n_b      = '0;
                n_a      = r_a + w_s_cnt;
                n_row_i0 = r_row_i0 + w_span;
                n_i0     = r_row_i0 + w_span;
            end else begin
                n_b  = r_b + w_s_cnt;
                n_i0 = r_i0 + w_s;
            end
        end
    end

    // output valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step   <= n_step;
        r_a      <= n_a;
        r_b      <= n_b;
        r_i0     <= n_i0;
        r_row_i0 <= n_row_i0;
    end

    // quad payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_v0   <= r_i0;
            r_v1   <= r_i0 + w_s;
            r_diag <= r_i0 + w_s + w_span;
            r_down <= r_i0 + w_span;
            r_slot <= r_count;
            r_last <= w_last;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.tri0_v0   = r_v0;
    assign o_out.tri0_v1   = r_v1;
    assign o_out.tri0_v2   = r_diag;
    assign o_out.tri1_v0   = r_v0;
    assign o_out.tri1_v1   = r_diag;
    assign o_out.tri1_v2   = r_down;
    assign o_out.slot      = r_slot;
    assign o_out.last_quad = r_last;

endmodule

`default_nettype wire

// File: hw/rtl/grid_cell_lod_triangle_indices.sv
// a cell beat goes into the queue, an idle walker pops it and registers its first quad
// throughput: one quad beat per cycle unless the sink stalls; (4 >> min(step, 2))^2
//   quads per cell, and the walker pauses between cells to load the next command
// the walker in the back end sets the rate; a 2-entry queue decouples the front
// reset: synchronous active low, clears queue, walker, output valid, slot count
// ---------------------------------------------------------------------------
// grid_cell_lod_triangle_indices
// triangle index generator for one grid cell at a chosen level of detail
// ---------------------------------------------------------------------------
`default_nettype none
`include "grid_cell_lod_triangle_indices_macros.svh"

module grid_cell_lod_triangle_indices (
    input  wire          i_clk,
    input  wire          i_rst_n,
    gclti_in_if.sink     i_in,
    gclti_out_if.source  o_out
);
    import gclti_pkg::*;

    logic    w_push;
    logic    w_pop;
    t_cmd    w_front_cmd;
    t_cmd    w_back_cmd;
    t_q_stat w_q_stat;

    logic    w_in_beat;
    logic    w_corners_ok;
    logic    w_stride_ok;
    logic    w_span_ok;

    // classify cells
    gclti_front u_front (
        .i_in     (i_in),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_cmd    (w_front_cmd)
    );

    // command queue
    gclti_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_back_cmd),
        .o_stat  (w_q_stat)
    );

    // walk sub-quads
    gclti_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_back_cmd),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

    // check terms
    assign w_in_beat    = i_in.valid && i_in.ready;
    assign w_corners_ok = (o_out.tri0_v0 == o_out.tri1_v0) &&
                          (o_out.tri0_v2 == o_out.tri1_v1);
    assign w_stride_ok  = $onehot(IDX_W'(o_out.tri0_v1 - o_out.tri0_v0));
    assign w_span_ok    = IDX_W'(o_out.tri0_v2 - o_out.tri0_v1) ==
                          IDX_W'(o_out.tri1_v2 - o_out.tri1_v0);

    // checks
    `GCLTI_ASSERT_NXT(a_push_fills_queue, i_clk, i_rst_n, w_in_beat, !w_q_stat.empty)
    `GCLTI_ASSERT_IMP(a_shared_corners, i_clk, i_rst_n, o_out.valid, w_corners_ok)
    `GCLTI_ASSERT_IMP(a_stride_pow2, i_clk, i_rst_n, o_out.valid, w_stride_ok)
    `GCLTI_ASSERT_IMP(a_span_match, i_clk, i_rst_n, o_out.valid, w_span_ok)

endmodule

`default_nettype wire

// File: dv/grid_cell_lod_triangle_indices_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// grid_cell_lod_triangle_indices_tb
// drives grid cells into the triangle index generator and checks every quad
// beat against an in-bench predictor of the sub-quad walk and the slot count,
// over phases of source idling and sink stalls
// ---------------------------------------------------------------------------
module grid_cell_lod_triangle_indices_tb;
    import gclti_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RAND_CELLS  = 52;

    typedef struct packed {
        logic                restart;
        logic [ROWCOL_W-1:0] row;
        logic [ROWCOL_W-1:0] col;
        logic [STEP_W-1:0]   step_log;
    } cell_t;

    typedef struct packed {
        t_idx tri0_v0;
        t_idx tri0_v1;
        t_idx tri0_v2;
        t_idx tri1_v0;
        t_idx tri1_v1;
        t_idx tri1_v2;
        t_idx slot;
        logic last_quad;
    } quad_t;

    logic i_clk;
    logic i_rst_n;

    cell_t cells_to_send[$];
    quad_t quads_due[$];
    t_idx  slot_count;
    logic  cell_beat_taken;
    int    source_idle_pct;
    int    sink_stall_pct;
    int    error_count;
    int    cycle_count;

    gclti_in_if  cell_if ();
    gclti_out_if quad_if ();

    grid_cell_lod_triangle_indices i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cell_if),
        .o_out   (quad_if)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic cell_t make_cell(logic restart, int row, int col, int step_log);
        cell_t c;
        c.restart  = restart;
        c.row      = row[ROWCOL_W-1:0];
        c.col      = col[ROWCOL_W-1:0];
        c.step_log = step_log[STEP_W-1:0];
        return c;
    endfunction

    // walk the cell's sub-quads at the chosen stride and queue the expected beats
    task automatic predict_cell_quads(input cell_t c);
        int unsigned sl, s, span, base, i0, diag, a, b;
        quad_t q;
        if (c.restart)
            slot_count = '0;
        sl   = (c.step_log > MAX_STEP) ? MAX_STEP : c.step_log;
        s    = 1 << sl;
        span = PITCH * s;
        base = c.row * DETAIL * PITCH + c.col * DETAIL;
        for (a = 0; a < DETAIL; a += s) begin
            i0 = base + a * PITCH;
            for (b = 0; b < DETAIL; b += s) begin
                diag        = i0 + s + span;
                q.tri0_v0   = i0[IDX_W-1:0];
                q.tri0_v1   = t_idx'(i0 + s);
                q.tri0_v2   = diag[IDX_W-1:0];
                q.tri1_v0   = i0[IDX_W-1:0];
                q.tri1_v1   = diag[IDX_W-1:0];
                q.tri1_v2   = t_idx'(i0 + span);
                q.slot      = slot_count;
                q.last_quad = (a + s >= DETAIL) && (b + s >= DETAIL);
                quads_due.push_back(q);
                slot_count  = slot_count + t_idx'(IDX_INC);
                i0 += s;
            end
        end
    endtask

    task automatic report_mismatch(input string field, input logic [IDX_W-1:0] want,
                                   input logic [IDX_W-1:0] got);
        $display("%0t mismatch %s expected %0d actual %0d", $time, field, want, got);
        error_count++;
    endtask

    // monitor: cell beats feed the predictor, quad beats are checked in order
    always @(posedge i_clk) begin
        quad_t got, want;
        if (i_rst_n) begin
            if (cell_if.valid && cell_if.ready) begin
                predict_cell_quads({cell_if.restart, cell_if.row, cell_if.col,
                                    cell_if.step_log});
                cell_beat_taken = 1'b1;
            end
            if (quad_if.valid && quad_if.ready) begin
                got = {quad_if.tri0_v0, quad_if.tri0_v1, quad_if.tri0_v2,
                       quad_if.tri1_v0, quad_if.tri1_v1, quad_if.tri1_v2,
                       quad_if.slot, quad_if.last_quad};
                if (quads_due.size() == 0) begin
                    $display("%0t unexpected quad beat, expected none, actual %h",
                             $time, got);
                    error_count++;
                end else begin
                    want = quads_due.pop_front();
                    if (got.tri0_v0 !== want.tri0_v0)
                        report_mismatch("tri0_v0", want.tri0_v0, got.tri0_v0);
                    if (got.tri0_v1 !== want.tri0_v1)
                        report_mismatch("tri0_v1", want.tri0_v1, got.tri0_v1);
                    if (got.tri0_v2 !== want.tri0_v2)
                        report_mismatch("tri0_v2", want.tri0_v2, got.tri0_v2);
                    if (got.tri1_v0 !== want.tri1_v0)
                        report_mismatch("tri1_v0", want.tri1_v0, got.tri1_v0);
                    if (got.tri1_v1 !== want.tri1_v1)
                        report_mismatch("tri1_v1", want.tri1_v1, got.tri1_v1);
                    if (got.tri1_v2 !== want.tri1_v2)
                        report_mismatch("tri1_v2", want.tri1_v2, got.tri1_v2);
                    if (got.slot !== want.slot)
                        report_mismatch("slot", want.slot, got.slot);
                    if (got.last_quad !== want.last_quad)
                        report_mismatch("last_quad", IDX_W'(want.last_quad),
                                        IDX_W'(got.last_quad));
                end
            end
        end
    end

    // driver: new cell beat or idle on the falling edge, random sink stalls
    always @(negedge i_clk) begin
        cell_t nxt;
        if (!i_rst_n) begin
            cell_if.valid <= 1'b0;
            quad_if.ready <= 1'b0;
        end else begin
            quad_if.ready <= ($urandom_range(99) >= sink_stall_pct);
            if (!cell_if.valid || cell_beat_taken) begin
                cell_beat_taken = 1'b0;
                if (cells_to_send.size() != 0 && $urandom_range(99) >= source_idle_pct) begin
                    nxt = cells_to_send.pop_front();
                    cell_if.valid    <= 1'b1;
                    cell_if.restart  <= nxt.restart;
                    cell_if.row      <= nxt.row;
                    cell_if.col      <= nxt.col;
                    cell_if.step_log <= nxt.step_log;
                end else begin
                    cell_if.valid    <= 1'b0;
                    cell_if.restart  <= 1'($urandom_range(1));
                    cell_if.row      <= 3'($urandom_range(7));
                    cell_if.col      <= 3'($urandom_range(7));
                    cell_if.step_log <= 2'($urandom_range(3));
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL grid_cell_lod_triangle_indices");
            $finish;
        end
    end

    // hold off until every cell is taken and every quad has come back
    task automatic drain_quads();
        while (cells_to_send.size() != 0 || cell_if.valid || quads_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // random cells, restarts kept rare so the slot count runs on
    task automatic run_random_phase(input int src_pct, input int snk_pct);
        source_idle_pct = src_pct;
        sink_stall_pct  = snk_pct;
        for (int n = 0; n < RAND_CELLS; n++)
            cells_to_send.push_back(make_cell($urandom_range(19) == 0,
                                              $urandom_range(7), $urandom_range(7),
                                              $urandom_range(3)));
        drain_quads();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        cell_if.valid    = 1'b0;
        cell_if.restart  = 1'b0;
        cell_if.row      = '0;
        cell_if.col      = '0;
        cell_if.step_log = '0;
        quad_if.ready    = 1'b0;
        slot_count       = '0;
        cell_beat_taken  = 1'b0;
        source_idle_pct  = 0;
        sink_stall_pct   = 0;
        error_count      = 0;
        cycle_count      = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: corner cells, every step, coarse step saturation, restarts
        cells_to_send.push_back(make_cell(1'b1, 0, 0, 0));
        cells_to_send.push_back(make_cell(1'b0, 7, 7, 0));
        cells_to_send.push_back(make_cell(1'b0, 0, 7, 1));
        cells_to_send.push_back(make_cell(1'b0, 7, 0, 1));
        cells_to_send.push_back(make_cell(1'b0, 3, 5, 2));
        cells_to_send.push_back(make_cell(1'b0, 7, 7, 3));
        cells_to_send.push_back(make_cell(1'b0, 0, 0, 3));
        cells_to_send.push_back(make_cell(1'b1, 5, 2, 1));
        cells_to_send.push_back(make_cell(1'b1, 2, 6, 2));
        cells_to_send.push_back(make_cell(1'b0, 4, 1, 0));
        cells_to_send.push_back(make_cell(1'b1, 7, 7, 3));
        cells_to_send.push_back(make_cell(1'b0, 6, 3, 0));
        drain_quads();

        run_random_phase(0, 0);
        run_random_phase(83, 0);
        run_random_phase(0, 83);
        run_random_phase(17, 17);

        repeat (32) @(negedge i_clk);
        if (error_count == 0 && quads_due.size() == 0)
            $display("PASS grid_cell_lod_triangle_indices");
        else
            $display("FAIL grid_cell_lod_triangle_indices");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/gclti_pkg.sv
hw/rtl/gclti_if.sv
hw/rtl/gclti_front.sv
hw/rtl/gclti_queue.sv
hw/rtl/gclti_back.sv
hw/rtl/grid_cell_lod_triangle_indices.sv
dv/grid_cell_lod_triangle_indices_tb.sv
